// ----- sv/i2c_master_register_access_top_defines.svh -----
// Assertion macros shared by the sequencer RTL.
// Checks are compiled only for simulation; synthesis sees empty bodies.
`ifndef I2C_MASTER_REGISTER_ACCESS_TOP_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication under async reset
`define I2CMRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cmra assertion failed");

// Next-cycle implication under async reset
`define I2CMRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cmra assertion failed");

`else

`define I2CMRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define I2CMRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/i2cmra_pkg.sv -----
`timescale 1ns / 1ps

package i2cmra_pkg;

    // Command kinds
    localparam logic [2:0] K_RD8  = 3'd0;
    localparam logic [2:0] K_RD16 = 3'd1;
    localparam logic [2:0] K_RDN  = 3'd2;
    localparam logic [2:0] K_WR8  = 3'd3;
    localparam logic [2:0] K_WR16 = 3'd4;

    // Step numbers inside a written byte (bits occupy steps 0..23)
    localparam logic [4:0] WR_ACK_REL    = 5'd24;
    localparam logic [4:0] WR_ACK_SCLH   = 5'd25;
    localparam logic [4:0] WR_ACK_SAMPLE = 5'd26;

    // Step numbers inside a read byte (bits occupy steps 1..16)
    localparam logic [4:0] RD_BITS_END = 5'd16;
    localparam logic [4:0] RD_ACK_OE   = 5'd17;
    localparam logic [4:0] RD_ACK_SDA  = 5'd18;
    localparam logic [4:0] RD_ACK_SCLH = 5'd19;

    // Start and stop pin steps
    localparam logic [4:0] SS_STEP0 = 5'd0;
    localparam logic [4:0] SS_STEP1 = 5'd1;
    localparam logic [4:0] SS_STEP2 = 5'd2;

    // Segment lengths
    localparam logic [4:0] LEN_START = 5'd3;
    localparam logic [4:0] LEN_STOP  = 5'd4;
    localparam logic [4:0] LEN_READ  = 5'd21;
    localparam logic [4:0] LEN_WRITE = 5'd28;

    // R/W bit appended to the device address
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_START1 = 11'b000_0000_0010,
        PH_ADDRW  = 11'b000_0000_0100,
        PH_REG    = 11'b000_0000_1000,
        PH_WD0    = 11'b000_0001_0000,
        PH_WD1    = 11'b000_0010_0000,
        PH_STOP1  = 11'b000_0100_0000,
        PH_START2 = 11'b000_1000_0000,
        PH_ADDRR  = 11'b001_0000_0000,
        PH_READ   = 11'b010_0000_0000,
        PH_STOP2  = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic        func;
        logic [2:0]  kind;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [15:0] write_data;
        logic [15:0] byte_count;
        logic        sda_in;
    } req_t;

    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        oe;
        logic        busy_res;
        logic        ack_seen;
        logic        data_valid;
        logic [15:0] data_value;
        logic        data_last;
        logic        cmd_rejected;
    } rsp_t;

    // Bit index and sub-step of a write step (step = 3*bit + sub)
    typedef struct packed {
        logic [2:0] bit_idx;
        logic [1:0] sub;
    } wstep_t;

    function automatic wstep_t wstep_decode(input logic [4:0] s);
        wstep_t     d;
        logic [4:0] k3;
        d.bit_idx = 3'd0;
        for (int i = 1; i < 8; i++)
        begin
            if (s >= 5'(3 * i))
            begin
                d.bit_idx = 3'(i);
            end
        end
        k3    = {1'b0, d.bit_idx, 1'b0} + {2'b00, d.bit_idx};
        d.sub = 2'(s - k3);
        return d;
    endfunction

    function automatic logic [4:0] seg_len(input phase_t ph);
        logic [4:0] len;
        case (ph)
            PH_START1, PH_START2: len = LEN_START;
            PH_STOP1, PH_STOP2:   len = LEN_STOP;
            PH_READ:              len = LEN_READ;
            default:              len = LEN_WRITE;
        endcase
        return len;
    endfunction

endpackage

// ----- sv/i2c_master_register_access_top.sv -----
`timescale 1ns / 1ps

// I2C master for register transactions, driven one pin update per request.
// Request channel (cmd_valid / cmd_stall / cmd): every request is one tick;
// with func set while idle and a known kind it also launches a read8, read16,
// read N, write8 or write16 command and performs the first start-condition step.
// Response channel (res_valid / res_stall / res): exactly one response per
// request, in order, carrying SCL/SDA/OE drive, busy, last ACK, and any read
// result completed on that tick.
// Path: a request is captured in the input register, and the sequencer step
// processes it into the response register; a held response keeps it waiting
// in the input register. Throughput: one request per cycle unless res_stall
// holds, set by the combinational sequencer step between the two registers.
// Stalls: while res_stall holds, the response register keeps its value; the
// input register still fills, then cmd_stall rises until the output drains.
// Reset: asynchronous, active low; both registers empty, sequencer idle with
// SCL and SDA released high and the SDA driver off.
module i2c_master_register_access_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  i2cmra_pkg::req_t  cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output i2cmra_pkg::rsp_t  res
);
    import i2cmra_pkg::*;

    logic req_valid_reg;
    req_t req_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_step;
    logic advance;
    logic fire;

    // Pipeline control
    assign advance   = !rsp_valid_reg || !res_stall;
    assign fire      = req_valid_reg && advance;
    assign cmd_stall = req_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (!cmd_stall)
            req_valid_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            req_reg <= cmd;
    end

    i2cmra_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req_reg),
        .rsp   (rsp_step)
    );

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            rsp_reg <= rsp_step;
    end

    assign res_valid = rsp_valid_reg;
    assign res       = rsp_reg;

endmodule

// ----- sv/i2cmra_seq.sv -----
`timescale 1ns / 1ps

`include "i2c_master_register_access_top_defines.svh"

module i2cmra_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  i2cmra_pkg::req_t  req,
    output i2cmra_pkg::rsp_t  rsp
);
    import i2cmra_pkg::*;

    // Sequencer state
    phase_t      phase_reg, phase_next;
    logic [4:0]  step_reg, step_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        oe_reg, oe_next;
    logic [2:0]  kind_reg, kind_next;
    logic [6:0]  dev_reg, dev_next;
    logic [7:0]  raddr_reg, raddr_next;
    logic [15:0] wdata_reg, wdata_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  high_reg, high_next;
    logic        ack_reg, ack_next;

    // Working values for the current tick
    phase_t      ph_c;
    phase_t      ph_adv;
    logic [4:0]  st_c;
    logic [4:0]  st_inc;
    logic        launch;
    logic        is_wr;
    logic [7:0]  tx_byte;
    wstep_t      wdec;
    logic        valid;
    logic [15:0] value;
    logic        last;

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        oe_next    = oe_reg;
        kind_next  = kind_reg;
        dev_next   = dev_reg;
        raddr_next = raddr_reg;
        wdata_next = wdata_reg;
        left_next  = left_reg;
        shift_next = shift_reg;
        high_next  = high_reg;
        ack_next   = ack_reg;
        valid      = 1'b0;
        value      = 16'd0;
        last       = 1'b0;
        ph_c       = phase_reg;
        st_c       = step_reg;

        // Command launch from idle; unknown kinds are dropped silently
        launch = req.func && (phase_reg == PH_IDLE) && (req.kind <= K_WR16);
        if (launch)
        begin
            kind_next  = req.kind;
            dev_next   = req.dev_addr;
            raddr_next = req.reg_addr;
            wdata_next = req.write_data;
            case (req.kind)
                K_RD8:   left_next = 16'd1;
                K_RD16:  left_next = 16'd2;
                K_RDN:   left_next = req.byte_count;
                default: left_next = 16'd0;
            endcase
            ph_c = PH_START1;
            st_c = 5'd0;
        end

        is_wr = (kind_next == K_WR8) || (kind_next == K_WR16);

        // Byte shifted out in a write segment
        case (ph_c)
            PH_ADDRW: tx_byte = {dev_next, RW_WRITE};
            PH_ADDRR: tx_byte = {dev_next, RW_READ};
            PH_REG:   tx_byte = raddr_next;
            PH_WD0:   tx_byte = wdata_next[7:0];
            default:  tx_byte = wdata_next[15:8];
        endcase
        wdec = wstep_decode(st_c);

        // One pin update per tick
        if (ph_c != PH_IDLE)
        begin
            case (ph_c)
                PH_START1, PH_START2:
                begin
                    if (st_c == SS_STEP0)
                        oe_next = 1'b1;
                    else if (st_c == SS_STEP1)
                        sda_next = 1'b0;
                    else
                        scl_next = 1'b0;
                end
                PH_STOP1, PH_STOP2:
                begin
                    if (st_c == SS_STEP0)
                        sda_next = 1'b0;
                    else if (st_c == SS_STEP1)
                        scl_next = 1'b1;
                    else if (st_c == SS_STEP2)
                        sda_next = 1'b1;
                    else
                        oe_next = 1'b0;
                end
                PH_READ:
                begin
                    if (st_c == 5'd0)
                    begin
                        oe_next    = 1'b0;
                        shift_next = 8'd0;
                    end
                    else if (st_c <= RD_BITS_END)
                    begin
                        // odd steps raise SCL, even steps sample and lower it
                        if (st_c[0])
                        begin
                            scl_next = 1'b1;
                        end
                        else
                        begin
                            shift_next = {shift_reg[6:0], req.sda_in};
                            scl_next   = 1'b0;
                        end
                    end
                    else if (st_c == RD_ACK_OE)
                        oe_next = 1'b1;
                    else if (st_c == RD_ACK_SDA)
                        sda_next = 1'b0;
                    else if (st_c == RD_ACK_SCLH)
                        scl_next = 1'b1;
                    else
                    begin
                        // master ACK done: byte complete
                        scl_next  = 1'b0;
                        left_next = left_reg - 16'd1;
                        if ((kind_next == K_RD16) && (left_next != 16'd0))
                        begin
                            high_next = shift_reg;
                        end
                        else
                        begin
                            valid = 1'b1;
                            value = (kind_next == K_RD16) ? {high_reg, shift_reg}
                                                          : {8'd0, shift_reg};
                            last  = (left_next == 16'd0);
                        end
                    end
                end
                default:
                begin
                    // write segment: SDA, SCL high, SCL low per bit, then ACK slot
                    if (st_c < WR_ACK_REL)
                    begin
                        if (wdec.sub == 2'd0)
                            sda_next = tx_byte[3'd7 - wdec.bit_idx];
                        else if (wdec.sub == 2'd1)
                            scl_next = 1'b1;
                        else
                            scl_next = 1'b0;
                    end
                    else if (st_c == WR_ACK_REL)
                        oe_next = 1'b0;
                    else if (st_c == WR_ACK_SCLH)
                        scl_next = 1'b1;
                    else if (st_c == WR_ACK_SAMPLE)
                    begin
                        ack_next = !req.sda_in;
                        scl_next = 1'b0;
                    end
                    else
                        oe_next = 1'b1;
                end
            endcase

            // Segment sequencing
            case (ph_c)
                PH_START1: ph_adv = PH_ADDRW;
                PH_ADDRW:  ph_adv = PH_REG;
                PH_REG:    ph_adv = is_wr ? PH_WD0 : PH_STOP1;
                PH_WD0:    ph_adv = (kind_next == K_WR16) ? PH_WD1 : PH_STOP2;
                PH_WD1:    ph_adv = PH_STOP2;
                PH_STOP1:  ph_adv = PH_START2;
                PH_START2: ph_adv = PH_ADDRR;
                PH_ADDRR:  ph_adv = (left_next != 16'd0) ? PH_READ : PH_STOP2;
                PH_READ:   ph_adv = (left_next != 16'd0) ? PH_READ : PH_STOP2;
                default:   ph_adv = PH_IDLE;
            endcase

            st_inc = st_c + 5'd1;
            if (st_inc >= seg_len(ph_c))
            begin
                step_next  = 5'd0;
                phase_next = ph_adv;
            end
            else
            begin
                step_next  = st_inc;
                phase_next = ph_c;
            end
        end
        else
        begin
            ph_adv = PH_IDLE;
            st_inc = 5'd0;
        end
    end

    // Result of this tick
    always_comb
    begin
        rsp.scl          = scl_next;
        rsp.sda          = sda_next;
        rsp.oe           = oe_next;
        rsp.busy_res     = (phase_next != PH_IDLE);
        rsp.ack_seen     = ack_next;
        rsp.data_valid   = valid;
        rsp.data_value   = value;
        rsp.data_last    = last;
        rsp.cmd_rejected = req.func && (phase_reg != PH_IDLE);
    end

    // State registers advance once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= 5'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            oe_reg    <= 1'b0;
            kind_reg  <= K_RD8;
            dev_reg   <= 7'd0;
            raddr_reg <= 8'd0;
            wdata_reg <= 16'd0;
            left_reg  <= 16'd0;
            shift_reg <= 8'd0;
            high_reg  <= 8'd0;
            ack_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            oe_reg    <= oe_next;
            kind_reg  <= kind_next;
            dev_reg   <= dev_next;
            raddr_reg <= raddr_next;
            wdata_reg <= wdata_next;
            left_reg  <= left_next;
            shift_reg <= shift_next;
            high_reg  <= high_next;
            ack_reg   <= ack_next;
        end
    end

    // Checks
    `I2CMRA_ASSERT_NXT(a_hold_no_fire, clk, rst_n, !fire, $stable(phase_reg) && $stable(step_reg))
    `I2CMRA_ASSERT_NXT(a_launch_start, clk, rst_n, fire && launch, (phase_reg == PH_START1) && (step_reg == 5'd1))
    `I2CMRA_ASSERT_IMP(a_data_in_read, clk, rst_n, fire && rsp.data_valid, phase_reg == PH_READ)
    `I2CMRA_ASSERT_IMP(a_idle_bus_free, clk, rst_n, phase_reg == PH_IDLE, scl_reg && sda_reg && !oe_reg)

endmodule
